/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the packetizer modules; they expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked at every rising clk edge outside reset
`define NRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// condition that must never be seen at a rising clk edge outside reset
`define NRP_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);
`else
`define NRP_ASSERT(lbl, prop, msg)
`define NRP_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* design/nrp_pkg.sv */
// ----------------------------------------------------------------------------
// nrp_pkg
// Types and constants of the H.264 NAL unit RTP packetizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrp_pkg;

  // configuration port
  typedef logic [1:0]  cfg_idx_t;
  typedef logic [15:0] cfg_data_t;

  localparam cfg_idx_t CFG_PACKET_SIZE    = 2'd0;
  localparam cfg_idx_t CFG_PAYLOAD_TYPE   = 2'd1;
  localparam cfg_idx_t CFG_START_SEQUENCE = 2'd2;

  // register reset values
  localparam logic [13:0] SIZE_RESET = 14'd1400;
  localparam logic [6:0]  PT_RESET   = 7'd96;
  localparam logic [15:0] SEQ_RESET  = 16'd0;

  // effective packet size limits
  localparam logic [13:0] SIZE_MIN = 14'd1040;
  localparam logic [13:0] SIZE_MAX = 14'd9000;

  // header overheads in bytes
  localparam logic [16:0] RTP_HDR_BYTES = 17'd12;
  localparam logic [13:0] FU_OVERHEAD   = 14'd14;

  // NAL and FU-A codes
  localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
  localparam logic [7:0] NAL_FNRI_MASK = 8'he0;
  localparam logic [7:0] FU_TYPE       = 8'd28;
  localparam logic [7:0] FU_START_BIT  = 8'h80;
  localparam logic [7:0] FU_END_BIT    = 8'h40;
  localparam logic [4:0] VCL_MAX_TYPE  = 5'd5;
  localparam logic [1:0] RTP_VER       = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAN,
    ST_EMIT
  } nrp_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic plan;
    logic emit;
  } nrp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic len_zero;
    logic last_pkt;
    logic out_free;
  } nrp_status_t;

endpackage

/* design/nrp_ifs.sv */
// ----------------------------------------------------------------------------
// nrp_ifs
// Valid/ready channels of the packetizer: NAL request, packet result and
// configuration write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nrp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  nal_header;
  logic [15:0] nal_length;
  logic        last_of_frame;
  logic [31:0] frame_time;

  modport source (output valid, nal_header, nal_length, last_of_frame, frame_time,
                  input ready);
  modport sink (input valid, nal_header, nal_length, last_of_frame, frame_time,
                output ready);
endinterface

interface nrp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;
  logic [31:0] packet_time;
  logic        is_fragment;
  logic [7:0]  frag_indicator;
  logic [7:0]  frag_header;
  logic [15:0] payload_offset;
  logic [13:0] payload_length;
  logic        last_packet;

  modport source (output valid, header_word, packet_time, is_fragment, frag_indicator,
                  frag_header, payload_offset, payload_length, last_packet,
                  input ready);
  modport sink (input valid, header_word, packet_time, is_fragment, frag_indicator,
                frag_header, payload_offset, payload_length, last_packet,
                output ready);
endinterface

interface nrp_cfg_if;
  logic                valid;
  logic                ready;
  nrp_pkg::cfg_idx_t   index;
  nrp_pkg::cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/nrp_dp.sv */
// ----------------------------------------------------------------------------
// nrp_dp
// Packetizer datapath: configuration registers, sequence counter, NAL unit
// registers, fragment walk and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nrp_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nrp_pkg::nrp_cmd_t    cmd,
  output nrp_pkg::nrp_status_t status,
  // request fields
  input  logic [7:0]           in_nal_header,
  input  logic [15:0]          in_nal_length,
  input  logic                 in_last_of_frame,
  input  logic [31:0]          in_frame_time,
  // configuration write
  input  logic                 cfg_we,
  input  nrp_pkg::cfg_idx_t    cfg_index,
  input  nrp_pkg::cfg_data_t   cfg_data,
  // result register
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [31:0]          out_header_word,
  output logic [31:0]          out_packet_time,
  output logic                 out_is_fragment,
  output logic [7:0]           out_frag_indicator,
  output logic [7:0]           out_frag_header,
  output logic [15:0]          out_payload_offset,
  output logic [13:0]          out_payload_length,
  output logic                 out_last_packet
);

  // configuration and counter
  logic [13:0] size_r;
  logic [6:0]  pt_r;
  logic [15:0] seq_r;
  logic [13:0] size_wr;

  // NAL unit held for the walk
  logic [7:0]  hdr_r;
  logic [15:0] len_r;
  logic        mark_r;
  logic [31:0] time_r;

  // walk registers
  logic        single_r;
  logic [13:0] chunk_r;
  logic [15:0] remaining_r;
  logic [15:0] offset_r;
  logic        first_r;

  // output register
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] header_r;
  logic [31:0] ptime_r;
  logic        frag_r;
  logic [7:0]  ind_r;
  logic [7:0]  fuh_r;
  logic [15:0] poff_r;
  logic [13:0] plen_r;
  logic        last_r;

  // packet being formed
  logic [4:0]  nal_type;
  logic        fits_single;
  logic        frag_end;
  logic [13:0] take;
  logic        marker;
  logic [7:0]  fu_ind;
  logic [7:0]  fu_hdr;

  // clamp the packet size as it is written
  always_comb begin
    size_wr = cfg_data[13:0];
    if (cfg_data[13:0] < nrp_pkg::SIZE_MIN) begin
      size_wr = nrp_pkg::SIZE_MIN;
    end else if (cfg_data[13:0] > nrp_pkg::SIZE_MAX) begin
      size_wr = nrp_pkg::SIZE_MAX;
    end
  end

  // per packet fields
  always_comb begin
    nal_type    = hdr_r[4:0];
    fits_single = ({1'b0, len_r} + nrp_pkg::RTP_HDR_BYTES) <= {3'b000, size_r};
    frag_end    = remaining_r <= {2'b00, chunk_r};
    take        = frag_end ? remaining_r[13:0] : chunk_r;
    if (single_r) begin
      marker = mark_r && (nal_type <= nrp_pkg::VCL_MAX_TYPE);
    end else begin
      marker = mark_r && frag_end;
    end
    fu_ind = (hdr_r & nrp_pkg::NAL_FNRI_MASK) | nrp_pkg::FU_TYPE;
    fu_hdr = (hdr_r & nrp_pkg::NAL_TYPE_MASK)
           | (first_r ? nrp_pkg::FU_START_BIT : 8'h00)
           | (frag_end ? nrp_pkg::FU_END_BIT : 8'h00);
  end

  // output register occupancy
  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers: configuration, sequence counter, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= nrp_pkg::SIZE_RESET;
      pt_r        <= nrp_pkg::PT_RESET;
      seq_r       <= nrp_pkg::SEQ_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.emit) begin
        seq_r <= seq_r + 16'd1;
      end
      if (cfg_we) begin
        case (cfg_index)
          nrp_pkg::CFG_PACKET_SIZE:    size_r <= size_wr;
          nrp_pkg::CFG_PAYLOAD_TYPE:   pt_r   <= cfg_data[6:0];
          nrp_pkg::CFG_START_SEQUENCE: seq_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // NAL unit capture and fragment walk
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hdr_r  <= in_nal_header;
      len_r  <= in_nal_length;
      mark_r <= in_last_of_frame;
      time_r <= in_frame_time;
    end
    if (cmd.plan) begin
      single_r    <= fits_single;
      chunk_r     <= size_r - nrp_pkg::FU_OVERHEAD;
      remaining_r <= len_r - 16'd1;
      offset_r    <= 16'd1;
      first_r     <= 1'b1;
    end
    if (cmd.emit) begin
      remaining_r <= remaining_r - {2'b00, take};
      offset_r    <= offset_r + {2'b00, take};
      first_r     <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      header_r <= {nrp_pkg::RTP_VER, 6'b000000, marker, pt_r, seq_r};
      ptime_r  <= time_r;
      if (single_r) begin
        frag_r <= 1'b0;
        ind_r  <= 8'h00;
        fuh_r  <= 8'h00;
        poff_r <= 16'd0;
        plen_r <= len_r[13:0];
        last_r <= 1'b1;
      end else begin
        frag_r <= 1'b1;
        ind_r  <= fu_ind;
        fuh_r  <= fu_hdr;
        poff_r <= offset_r;
        plen_r <= take;
        last_r <= frag_end;
      end
    end
  end

  // status to controller
  assign status.len_zero = (len_r == 16'd0);
  assign status.last_pkt = single_r || frag_end;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_header_word    = header_r;
  assign out_packet_time    = ptime_r;
  assign out_is_fragment    = frag_r;
  assign out_frag_indicator = ind_r;
  assign out_frag_header    = fuh_r;
  assign out_payload_offset = poff_r;
  assign out_payload_length = plen_r;
  assign out_last_packet    = last_r;

  // checks
  `NRP_ASSERT(a_emit_fills_out, cmd.emit |=> out_valid_r, "emitted packet not held in output register")
  `NRP_ASSERT(a_seq_step, cmd.emit |=> seq_r == ($past(seq_r) + 16'd1), "sequence counter did not advance by one")
  `NRP_ASSERT(a_walk_shrinks, cmd.emit && !status.last_pkt |=> remaining_r < $past(remaining_r), "fragment walk did not consume bytes")

endmodule

/* design/nrp_ctrl.sv */
// ----------------------------------------------------------------------------
// nrp_ctrl
// Packetizer controller: takes a request, plans it, then steps the datapath
// through its packets while the output register has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nrp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nrp_pkg::nrp_status_t status,
  output nrp_pkg::nrp_cmd_t    cmd
);

  nrp_pkg::nrp_state_t state_r;
  nrp_pkg::nrp_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nrp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nrp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = nrp_pkg::ST_PLAN;
        end
      end
      nrp_pkg::ST_PLAN: begin
        state_nxt = status.len_zero ? nrp_pkg::ST_IDLE : nrp_pkg::ST_EMIT;
      end
      nrp_pkg::ST_EMIT: begin
        if (status.out_free && status.last_pkt) begin
          state_nxt = nrp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nrp_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.plan    = 1'b0;
    cmd.emit    = 1'b0;
    case (state_r)
      nrp_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      nrp_pkg::ST_PLAN: cmd.plan = 1'b1;
      nrp_pkg::ST_EMIT: cmd.emit = status.out_free;
      default: ;
    endcase
  end

  // checks
  `NRP_ASSERT(a_capture_plan, cmd.capture |=> state_r == nrp_pkg::ST_PLAN, "request not followed by planning")
  `NRP_ASSERT(a_empty_skip, cmd.plan && status.len_zero |=> state_r == nrp_pkg::ST_IDLE, "empty unit did not return to idle")
  `NRP_ASSERT(a_last_idle, cmd.emit && status.last_pkt |=> state_r == nrp_pkg::ST_IDLE, "final packet did not end the walk")

endmodule

/* design/h264_nal_rtp_packetizer_core.sv */
// ----------------------------------------------------------------------------
// h264_nal_rtp_packetizer_core
// Plans RTP packets (single NAL or FU-A fragments) for H.264 NAL units.
// ----------------------------------------------------------------------------
// order: a request is captured in ST_IDLE and planned in ST_PLAN; ST_EMIT then loads
// its packets into the output register, N packets per NAL unit (1 to 64), one packet per
//   cycle while the sink takes them; an empty unit returns from ST_PLAN to ST_IDLE
// the next request is taken once the final packet is loaded into the output reg
// reset: synchronous, active low; packet_size 1400, payload_type 96, sequence 0
`timescale 1ns / 1ps

module h264_nal_rtp_packetizer_core (
  input logic            clk,
  input logic            rst_n,
  nrp_in_if.sink         in_req,
  nrp_out_if.source      out_pkt,
  nrp_cfg_if.sink        cfg_wr
);

  nrp_pkg::nrp_cmd_t    cmd;
  nrp_pkg::nrp_status_t status;

  // configuration writes are always taken
  assign cfg_wr.ready = 1'b1;

  nrp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  nrp_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_nal_header      (in_req.nal_header),
    .in_nal_length      (in_req.nal_length),
    .in_last_of_frame   (in_req.last_of_frame),
    .in_frame_time      (in_req.frame_time),
    .cfg_we             (cfg_wr.valid),
    .cfg_index          (cfg_wr.index),
    .cfg_data           (cfg_wr.data),
    .out_ready          (out_pkt.ready),
    .out_valid          (out_pkt.valid),
    .out_header_word    (out_pkt.header_word),
    .out_packet_time    (out_pkt.packet_time),
    .out_is_fragment    (out_pkt.is_fragment),
    .out_frag_indicator (out_pkt.frag_indicator),
    .out_frag_header    (out_pkt.frag_header),
    .out_payload_offset (out_pkt.payload_offset),
    .out_payload_length (out_pkt.payload_length),
    .out_last_packet    (out_pkt.last_packet)
  );

endmodule
